// File: sv/oit_pkg.sv
package oit_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int KIND_W  = 3;
    localparam int IDX_W   = 7;
    localparam int HI_W    = 32;
    localparam int LO_W    = 64;
    localparam int STAT_W  = 2;
    localparam int FOUND_W = 6;
    localparam int TOTAL_W = 7;

    localparam logic [KIND_W-1:0] K_SET       = 3'd0;
    localparam logic [KIND_W-1:0] K_INSERT    = 3'd1;
    localparam logic [KIND_W-1:0] K_ERASE     = 3'd2;
    localparam logic [KIND_W-1:0] K_FIND_VAL  = 3'd3;
    localparam logic [KIND_W-1:0] K_FIND_NULL = 3'd4;
    localparam logic [KIND_W-1:0] K_MARK_NULL = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [HI_W-1:0] hi;
        logic [LO_W-1:0] lo;
        logic            mark;
    } t_entry;

    typedef struct packed {
        logic             do_set;
        logic             do_ins;
        logic             do_era;
        logic             do_mark;
        logic             do_find_val;
        logic             do_find_null;
        logic [IDX_W-1:0] pos;
        logic [IDX_W-1:0] stop;
        logic [HI_W-1:0]  vhi;
        logic [LO_W-1:0]  vlo;
    } t_cmd;

endpackage

// File: sv/oit_in_if.sv
interface oit_in_if;
    logic                       valid;
    logic                       ready;
    logic [oit_pkg::KIND_W-1:0] kind;
    logic [oit_pkg::IDX_W-1:0]  index;
    logic [oit_pkg::IDX_W-1:0]  end_index;
    logic [oit_pkg::HI_W-1:0]   value_high;
    logic [oit_pkg::LO_W-1:0]   value_low;

    modport source (output valid, kind, index, end_index, value_high, value_low,
                    input ready);
    modport sink (input valid, kind, index, end_index, value_high, value_low,
                  output ready);
endinterface

// File: sv/oit_out_if.sv
interface oit_out_if;
    logic                        valid;
    logic                        ready;
    logic [oit_pkg::STAT_W-1:0]  status;
    logic [oit_pkg::FOUND_W-1:0] found_index;
    logic [oit_pkg::TOTAL_W-1:0] entry_total;

    modport source (output valid, status, found_index, entry_total, input ready);
    modport sink (input valid, status, found_index, entry_total, output ready);
endinterface

// File: sv/oit_cell.sv
module oit_cell #(
    parameter int CMPW     = 7,
    parameter int CELL_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  oit_pkg::t_cmd   i_cmd,
    input  oit_pkg::t_entry i_below,
    input  oit_pkg::t_entry i_above,
    output oit_pkg::t_entry o_entry,
    output logic            o_hit
);

    localparam logic [CMPW-1:0] MY_POS = CMPW'(CELL_IDX);

    logic [oit_pkg::HI_W-1:0] r_hi;
    logic [oit_pkg::LO_W-1:0] r_lo;
    logic                     r_mark;
    logic                     r_hit;
    oit_pkg::t_entry          n_entry;
    logic                     n_hit;
    logic [CMPW-1:0]          w_pos;
    logic [CMPW-1:0]          w_stop;
    logic                     w_at;
    logic                     w_match;

    assign o_entry = '{hi: r_hi, lo: r_lo, mark: r_mark};
    assign o_hit   = r_hit;
    assign w_pos   = CMPW'(i_cmd.pos);
    assign w_stop  = CMPW'(i_cmd.stop);
    assign w_at    = (MY_POS == w_pos);
    assign w_match = !r_mark && (r_hi == i_cmd.vhi) && (r_lo == i_cmd.vlo);

    always_comb begin
        n_entry = o_entry;
        if ((i_cmd.do_set && w_at) || (i_cmd.do_ins && w_at)) begin
            n_entry = '{hi: i_cmd.vhi, lo: i_cmd.vlo, mark: 1'b0};
        end else if (i_cmd.do_ins && (MY_POS > w_pos)) begin
            n_entry = i_below;
        end else if (i_cmd.do_era && (MY_POS >= w_pos)) begin
            n_entry = i_above;
        end else if (i_cmd.do_mark && w_at) begin
            n_entry.mark = 1'b1;
        end
        n_hit = (MY_POS >= w_pos) && (MY_POS < w_stop) &&
                ((i_cmd.do_find_val && w_match) || (i_cmd.do_find_null && r_mark));
    end

    always_ff @(posedge i_clk) begin
        r_hi  <= n_entry.hi;
        r_lo  <= n_entry.lo;
        r_hit <= n_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark <= 1'b0;
        end else begin
            r_mark <= n_entry.mark;
        end
    end

endmodule

// File: sv/oit_first_hit.sv
module oit_first_hit #(
    parameter int DEPTH = oit_pkg::DEPTH_DEF,
    parameter int IW    = 6
) (
    input  logic [DEPTH-1:0] i_hits,
    output logic             o_any,
    output logic [IW-1:0]    o_index
);

    logic [DEPTH-1:0] w_lowest;

    // isolate the lowest set bit, then encode the one-hot word
    assign w_lowest = i_hits & (~i_hits + DEPTH'(1));
    assign o_any    = |i_hits;

    always_comb begin
        o_index = '0;
        for (int b = 0; b < IW; b++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (((i >> b) & 1) == 1) begin
                    o_index[b] = o_index[b] | w_lowest[i];
                end
            end
        end
    end

endmodule

// File: sv/ordered_id_table_with_null_marks_core.sv
// channel | dir | payload                                       | handshake
// i_in    | in  | kind, index, end_index, value_high, value_low | valid/ready
// o_out   | out | status, found_index, entry_total              | valid/ready
//
// set, insert, erase, mark null and rejected operations: result registered at
// the accept edge; all cells shift in parallel.
// find value and find null: cells compare in the accept cycle, the first-hit
// encoder resolves in the next; input is held off until the search resolves.
// reset clears the entry count, the null marks, the search flag and the output valid.
// a held result stalls input until it is taken, possibly in the same cycle.
module ordered_id_table_with_null_marks_core #(
    parameter int DEPTH = oit_pkg::DEPTH_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    oit_in_if.sink    i_in,
    oit_out_if.source o_out
);

    localparam int CW   = $clog2(DEPTH + 1);
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMPW = (CW > oit_pkg::IDX_W) ? CW : oit_pkg::IDX_W;

    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic                         r_busy;
    logic                         r_out_valid;
    logic [oit_pkg::STAT_W-1:0]   r_status;
    logic [oit_pkg::FOUND_W-1:0]  r_found;
    logic [oit_pkg::TOTAL_W-1:0]  r_total;

    logic                         w_accept;
    logic                         w_ok;
    logic                         w_find;
    logic [CMPW-1:0]              w_pos;
    logic [CMPW-1:0]              w_stop;
    logic [CMPW-1:0]              w_cnt;
    oit_pkg::t_cmd                w_cmd;
    oit_pkg::t_entry              w_entry [DEPTH];
    logic [DEPTH-1:0]             w_hits;
    logic                         w_any;
    logic [IW-1:0]                w_first;

    assign w_accept    = i_in.valid && i_in.ready;
    assign i_in.ready  = !r_busy && (!r_out_valid || o_out.ready);
    assign w_pos       = CMPW'(i_in.index);
    assign w_stop      = CMPW'(i_in.end_index);
    assign w_cnt       = CMPW'(r_count);

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.found_index = r_found;
    assign o_out.entry_total = r_total;

    always_comb begin
        w_ok   = 1'b0;
        w_find = 1'b0;
        case (i_in.kind)
            oit_pkg::K_SET, oit_pkg::K_ERASE, oit_pkg::K_MARK_NULL: begin
                w_ok = (w_pos < w_cnt);
            end
            oit_pkg::K_INSERT: begin
                w_ok = (w_pos <= w_cnt) && (r_count != CW'(DEPTH));
            end
            oit_pkg::K_FIND_VAL, oit_pkg::K_FIND_NULL: begin
                w_find = 1'b1;
                w_ok   = (w_pos <= w_stop) && (w_stop <= w_cnt);
            end
            default: begin
                w_ok = 1'b0;
            end
        endcase

        w_cmd.do_set       = w_accept && w_ok && (i_in.kind == oit_pkg::K_SET);
        w_cmd.do_ins       = w_accept && w_ok && (i_in.kind == oit_pkg::K_INSERT);
        w_cmd.do_era       = w_accept && w_ok && (i_in.kind == oit_pkg::K_ERASE);
        w_cmd.do_mark      = w_accept && w_ok && (i_in.kind == oit_pkg::K_MARK_NULL);
        w_cmd.do_find_val  = w_accept && w_ok && (i_in.kind == oit_pkg::K_FIND_VAL);
        w_cmd.do_find_null = w_accept && w_ok && (i_in.kind == oit_pkg::K_FIND_NULL);
        w_cmd.pos          = i_in.index;
        w_cmd.stop         = i_in.end_index;
        w_cmd.vhi          = i_in.value_high;
        w_cmd.vlo          = i_in.value_low;

        n_count = r_count;
        if (w_cmd.do_ins) begin
            n_count = r_count + CW'(1);
        end else if (w_cmd.do_era) begin
            n_count = r_count - CW'(1);
        end
    end

    // the cell chain
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        oit_pkg::t_entry w_below;
        oit_pkg::t_entry w_above;

        if (g == 0) begin : g_bottom
            assign w_below = '0;
        end else begin : g_mid_lo
            assign w_below = w_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_top
            assign w_above = '0;
        end else begin : g_mid_hi
            assign w_above = w_entry[g+1];
        end

        oit_cell #(
            .CMPW     (CMPW),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_below (w_below),
            .i_above (w_above),
            .o_entry (w_entry[g]),
            .o_hit   (w_hits[g])
        );
    end

    oit_first_hit #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_first_hit (
        .i_hits  (w_hits),
        .o_any   (w_any),
        .o_index (w_first)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (r_busy) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (w_accept) begin
                r_busy      <= w_find && w_ok;
                r_out_valid <= !(w_find && w_ok);
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_status <= w_any ? oit_pkg::ST_OK : oit_pkg::ST_MISS;
            r_found  <= w_any ? oit_pkg::FOUND_W'(w_first) : '0;
            r_total  <= oit_pkg::TOTAL_W'(r_count);
        end else if (w_accept) begin
            r_status <= w_ok ? oit_pkg::ST_OK : oit_pkg::ST_BAD;
            r_found  <= '0;
            r_total  <= oit_pkg::TOTAL_W'(n_count);
        end
    end

    a_busy_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |=> !r_busy && r_out_valid)
        else $error("search did not resolve in one cycle");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !i_in.ready)
        else $error("input taken while a search is pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("entry count changed without a transaction");

endmodule
